### sv/bsp_point_location_core_assert.svh
// Assertion macros shared by the BSP point location RTL.
`ifndef BSP_POINT_LOCATION_CORE_ASSERT_SVH
`define BSP_POINT_LOCATION_CORE_ASSERT_SVH

// Condition holds at every edge outside reset.
`define BSPL_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define BSPL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define BSPL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/bspl_pkg.sv
// Types and constants shared by the BSP point location modules.
package bspl_pkg;

  localparam logic [1:0] OP_PLANE  = 2'd0;
  localparam logic [1:0] OP_NODE   = 2'd1;
  localparam logic [1:0] OP_LOCATE = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam int SLOT_W   = 12;
  localparam int NORM_W   = 16;
  localparam int COORD_W  = 24;
  localparam int CHILD_W  = 14;
  localparam int LEAF_W   = 13;
  localparam int PROD_W   = COORD_W + NORM_W;
  localparam int ACC_W    = 44;
  localparam int CNT_W    = 17;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef struct packed {
    logic [1:0]                 op;
    logic [SLOT_W-1:0]          slot;
    logic signed [NORM_W-1:0]   nx;
    logic signed [NORM_W-1:0]   ny;
    logic signed [NORM_W-1:0]   nz;
    logic signed [COORD_W-1:0]  off;
    logic [SLOT_W-1:0]          plane;
    logic signed [CHILD_W-1:0]  front;
    logic signed [CHILD_W-1:0]  back;
    logic signed [COORD_W-1:0]  px;
    logic signed [COORD_W-1:0]  py;
    logic signed [COORD_W-1:0]  pz;
  } cmd_t;

  typedef struct packed {
    logic signed [NORM_W-1:0]   nx;
    logic signed [NORM_W-1:0]   ny;
    logic signed [NORM_W-1:0]   nz;
    logic signed [COORD_W-1:0]  off;
  } plane_t;

  typedef struct packed {
    logic [SLOT_W-1:0]          plane;
    logic signed [CHILD_W-1:0]  front;
    logic signed [CHILD_W-1:0]  back;
  } node_t;

endpackage

### sv/bsp_point_location_core.sv
// BSP point location core: locates the tree leaf that contains a 3D query point.
//
// Words on the item channel either load one plane entry (op 0), load one node entry
// (op 1) or locate a point (op 2); op 3 is dropped. A four-word queue sits between
// the front end that accepts words and the back end that runs them, so the input
// side keeps taking words until the queue is full, also while a walk is in progress
// or a result waits. In the back end a table write is made as the word is taken.
// A locate visits, per tree level, a node table read, a plane table read, three
// multiplies through one shared 24x16 multiplier plus the final accumulate, and a
// branch decision, then loads the result register. Tables have no clear on reset:
// they must be loaded before a walk reads them. depth_error is set, with leaf_index
// 0, when the walk exceeds MAX_DEPTH levels, names a node at or past NODE_COUNT or
// a leaf at or past LEAF_COUNT.
module bsp_point_location_core
  import bspl_pkg::*;
#(
  parameter int NODE_COUNT  = 4096,
  parameter int PLANE_COUNT = 4096,
  parameter int LEAF_COUNT  = 8192,
  parameter int MAX_DEPTH   = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_ready,
  input  logic [1:0]                 op,
  input  logic [SLOT_W-1:0]          entry_index,
  input  logic signed [NORM_W-1:0]   normal_x,
  input  logic signed [NORM_W-1:0]   normal_y,
  input  logic signed [NORM_W-1:0]   normal_z,
  input  logic signed [COORD_W-1:0]  plane_ofs,
  input  logic [SLOT_W-1:0]          node_plane,
  input  logic signed [CHILD_W-1:0]  front_child,
  input  logic signed [CHILD_W-1:0]  back_child,
  input  logic signed [COORD_W-1:0]  point_x,
  input  logic signed [COORD_W-1:0]  point_y,
  input  logic signed [COORD_W-1:0]  point_z,
  output logic                       result_valid,
  input  logic                       result_ready,
  output logic [LEAF_W-1:0]          leaf_index,
  output logic                       depth_error
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  bspl_front u_front (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .op           (op),
    .entry_index  (entry_index),
    .normal_x     (normal_x),
    .normal_y     (normal_y),
    .normal_z     (normal_z),
    .plane_ofs    (plane_ofs),
    .node_plane   (node_plane),
    .front_child  (front_child),
    .back_child   (back_child),
    .point_x      (point_x),
    .point_y      (point_y),
    .point_z      (point_z),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd)
  );

  bspl_walk #(
    .NODE_COUNT  (NODE_COUNT),
    .PLANE_COUNT (PLANE_COUNT),
    .LEAF_COUNT  (LEAF_COUNT),
    .MAX_DEPTH   (MAX_DEPTH)
  ) u_walk (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .leaf_index   (leaf_index),
    .depth_error  (depth_error)
  );

endmodule

### sv/bspl_front.sv
// Front end: accepts input words, drops unused ops, queues commands for the back end.
module bspl_front
  import bspl_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_ready,
  input  logic [1:0]                 op,
  input  logic [SLOT_W-1:0]          entry_index,
  input  logic signed [NORM_W-1:0]   normal_x,
  input  logic signed [NORM_W-1:0]   normal_y,
  input  logic signed [NORM_W-1:0]   normal_z,
  input  logic signed [COORD_W-1:0]  plane_ofs,
  input  logic [SLOT_W-1:0]          node_plane,
  input  logic signed [CHILD_W-1:0]  front_child,
  input  logic signed [CHILD_W-1:0]  back_child,
  input  logic signed [COORD_W-1:0]  point_x,
  input  logic signed [COORD_W-1:0]  point_y,
  input  logic signed [COORD_W-1:0]  point_z,
  output logic                       cmd_valid,
  input  logic                       cmd_ready,
  output cmd_t                       cmd
);

  cmd_t                queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;
  logic                push;
  logic                pop;
  cmd_t                cmd_in;

  assign item_ready = (count != (QPTR_W+1)'(QUEUE_DEPTH));
  assign push       = item_valid && item_ready && (op != OP_NONE);
  assign pop        = cmd_valid && cmd_ready;
  assign cmd_valid  = (count != '0);
  assign cmd        = queue[rd_ptr];

  always_comb begin
    cmd_in.op    = op;
    cmd_in.slot  = entry_index;
    cmd_in.nx    = normal_x;
    cmd_in.ny    = normal_y;
    cmd_in.nz    = normal_z;
    cmd_in.off   = plane_ofs;
    cmd_in.plane = node_plane;
    cmd_in.front = front_child;
    cmd_in.back  = back_child;
    cmd_in.px    = point_x;
    cmd_in.py    = point_y;
    cmd_in.pz    = point_z;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### sv/bspl_walk.sv
// Back end: plane and node tables, tree walk with a shared multiply-accumulate, result register.
`include "bsp_point_location_core_assert.svh"

module bspl_walk
  import bspl_pkg::*;
#(
  parameter int NODE_COUNT  = 4096,
  parameter int PLANE_COUNT = 4096,
  parameter int LEAF_COUNT  = 8192,
  parameter int MAX_DEPTH   = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  cmd_t              cmd,
  output logic              result_valid,
  input  logic              result_ready,
  output logic [LEAF_W-1:0] leaf_index,
  output logic              depth_error
);

  localparam int NODE_AW  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int PLANE_AW = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
  localparam int VIS_W    = $clog2(MAX_DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_NODE  = 3'd1;
  localparam logic [2:0] S_PLANE = 3'd2;
  localparam logic [2:0] S_MAC   = 3'd3;
  localparam logic [2:0] S_DEC   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  node_t  node_mem  [NODE_COUNT];
  plane_t plane_mem [PLANE_COUNT];

  logic [2:0]                state;
  logic [1:0]                step;
  logic [CHILD_W-2:0]        cur;
  logic [VIS_W-1:0]          visits;
  logic signed [COORD_W-1:0] px;
  logic signed [COORD_W-1:0] py;
  logic signed [COORD_W-1:0] pz;
  node_t                     node_q;
  plane_t                    plane_q;
  logic                      plane_ok;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;
  logic [LEAF_W-1:0]         leaf_hold;
  logic                      err_hold;

  logic                      take;
  logic                      node_we;
  logic                      plane_we;
  logic signed [COORD_W-1:0] mul_a;
  logic signed [NORM_W-1:0]  mul_b;
  logic signed [CHILD_W-1:0] next;
  logic [LEAF_W-1:0]         leaf_num;
  logic [VIS_W-1:0]          visits_next;
  logic                      load_result;

  assign cmd_ready = (state == S_IDLE);
  assign take      = cmd_valid && cmd_ready;
  assign plane_we  = take && (cmd.op == OP_PLANE) &&
                     (CNT_W'(cmd.slot) < CNT_W'(PLANE_COUNT));
  assign node_we   = take && (cmd.op == OP_NODE) &&
                     (CNT_W'(cmd.slot) < CNT_W'(NODE_COUNT));

  always_comb begin
    case (step)
      2'd0: begin
        mul_a = px;
        mul_b = plane_q.nx;
      end
      2'd1: begin
        mul_a = py;
        mul_b = plane_q.ny;
      end
      default: begin
        mul_a = pz;
        mul_b = plane_q.nz;
      end
    endcase
  end

  assign next        = (!plane_ok || !acc[ACC_W-1]) ? node_q.front : node_q.back;
  assign leaf_num    = ~next[LEAF_W-1:0];
  assign visits_next = visits + 1'b1;
  assign load_result = (state == S_DONE) && (!result_valid || result_ready);

  always_ff @(posedge clk) begin
    if (plane_we) begin
      plane_mem[PLANE_AW'(cmd.slot)] <= '{nx: cmd.nx, ny: cmd.ny, nz: cmd.nz, off: cmd.off};
    end
    if (node_we) begin
      node_mem[NODE_AW'(cmd.slot)] <= '{plane: cmd.plane, front: cmd.front, back: cmd.back};
    end
    if (state == S_NODE) begin
      node_q <= node_mem[NODE_AW'(cur)];
    end
    if (state == S_PLANE) begin
      plane_q <= plane_mem[PLANE_AW'(node_q.plane)];
    end
  end

  always_ff @(posedge clk) begin
    if (take && (cmd.op == OP_LOCATE)) begin
      px <= cmd.px;
      py <= cmd.py;
      pz <= cmd.pz;
    end
    if (state == S_PLANE) begin
      plane_ok <= (CNT_W'(node_q.plane) < CNT_W'(PLANE_COUNT));
    end
    if (state == S_MAC) begin
      prod <= mul_a * mul_b;
      if (step == 2'd0) begin
        acc <= -(ACC_W'(plane_q.off) <<< 14);
      end else begin
        acc <= acc + ACC_W'(prod);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step         <= '0;
      cur          <= '0;
      visits       <= '0;
      leaf_hold    <= '0;
      err_hold     <= 1'b0;
      result_valid <= 1'b0;
      leaf_index   <= '0;
      depth_error  <= 1'b0;
    end else begin
      if (load_result) begin
        result_valid <= 1'b1;
        leaf_index   <= leaf_hold;
        depth_error  <= err_hold;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (take && (cmd.op == OP_LOCATE)) begin
            cur    <= '0;
            visits <= '0;
            state  <= S_NODE;
          end
        end
        S_NODE: begin
          state <= S_PLANE;
        end
        S_PLANE: begin
          step  <= '0;
          state <= S_MAC;
        end
        S_MAC: begin
          step <= step + 1'b1;
          if (step == 2'd3) begin
            state <= S_DEC;
          end
        end
        S_DEC: begin
          visits <= visits_next;
          if (next[CHILD_W-1]) begin
            if (CNT_W'(leaf_num) < CNT_W'(LEAF_COUNT)) begin
              leaf_hold <= leaf_num;
              err_hold  <= 1'b0;
            end else begin
              leaf_hold <= '0;
              err_hold  <= 1'b1;
            end
            state <= S_DONE;
          end else if ((CNT_W'(next[CHILD_W-2:0]) >= CNT_W'(NODE_COUNT)) ||
                       (visits_next >= VIS_W'(MAX_DEPTH))) begin
            leaf_hold <= '0;
            err_hold  <= 1'b1;
            state     <= S_DONE;
          end else begin
            cur   <= next[CHILD_W-2:0];
            state <= S_NODE;
          end
        end
        S_DONE: begin
          if (load_result) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `BSPL_ASSERT_ALWAYS(a_visits_bound, visits <= VIS_W'(MAX_DEPTH), "walk ran past depth limit")
  `BSPL_ASSERT_IMP(a_err_leaf_zero, result_valid && depth_error, leaf_index == '0, "error result carries a leaf")
  `BSPL_ASSERT_NEXT(a_locate_starts, take && (cmd.op == OP_LOCATE), state == S_NODE && visits == '0, "locate did not start a walk")
  `BSPL_ASSERT_NEXT(a_result_loaded, load_result, result_valid && state == S_IDLE, "finished walk lost its result")

endmodule

### bench/tb_bsp_point_location_core.sv
// Self-checking testbench for bsp_point_location_core: tree loads, point queries, handshakes.
module tb_bsp_point_location_core;
  import bspl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODE_CNT    = 4096;
  localparam int PLANE_CNT   = 4096;
  localparam int LEAF_CNT    = 8192;
  localparam int DEPTH_LIMIT = 64;
  localparam int LONG_HOLD   = 300;
  localparam int SETTLE      = 500;
  localparam int QUIET_LIMIT = 5000;

  typedef struct packed {
    logic [LEAF_W-1:0] leaf;
    logic              err;
  } located_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      item_valid = 1'b0;
  logic                      item_ready;
  logic [1:0]                op = OP_NONE;
  logic [SLOT_W-1:0]         entry_index = '0;
  logic signed [NORM_W-1:0]  normal_x = '0;
  logic signed [NORM_W-1:0]  normal_y = '0;
  logic signed [NORM_W-1:0]  normal_z = '0;
  logic signed [COORD_W-1:0] plane_ofs = '0;
  logic [SLOT_W-1:0]         node_plane = '0;
  logic signed [CHILD_W-1:0] front_child = '0;
  logic signed [CHILD_W-1:0] back_child = '0;
  logic signed [COORD_W-1:0] point_x = '0;
  logic signed [COORD_W-1:0] point_y = '0;
  logic signed [COORD_W-1:0] point_z = '0;
  logic                      result_valid;
  logic                      result_ready = 1'b0;
  logic [LEAF_W-1:0]         leaf_index;
  logic                      depth_error;

  plane_t            plane_mem [PLANE_CNT];
  node_t             node_mem  [NODE_CNT];
  bit                plane_set [PLANE_CNT];
  bit                node_set  [NODE_CNT];
  located_t          leaf_due [$];
  logic [SLOT_W-1:0] tree_planes [8];
  logic [SLOT_W-1:0] tree_nodes  [64];
  int unsigned       tree_size;

  bit          tx_steady = 1'b0;
  logic        rx_steady = 1'b0;
  logic        hold_req = 1'b0;
  logic        hold_ack = 1'b0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned n_words = 0, n_plane = 0, n_node = 0, n_dropped = 0;
  int unsigned n_query = 0, n_deep = 0, n_checked = 0, n_fail = 0, n_skipped = 0;

  bsp_point_location_core #(
    .NODE_COUNT (NODE_CNT),
    .PLANE_COUNT(PLANE_CNT),
    .LEAF_COUNT (LEAF_CNT),
    .MAX_DEPTH  (DEPTH_LIMIT)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .op          (op),
    .entry_index (entry_index),
    .normal_x    (normal_x),
    .normal_y    (normal_y),
    .normal_z    (normal_z),
    .plane_ofs   (plane_ofs),
    .node_plane  (node_plane),
    .front_child (front_child),
    .back_child  (back_child),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_z     (point_z),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .leaf_index  (leaf_index),
    .depth_error (depth_error)
  );

  always #5 clk = ~clk;

  // Walk the mirrored tables; returns 0 if the walk would touch an unloaded entry.
  function automatic bit locate(input cmd_t w, output located_t r);
    int          cur;
    int          hop;
    int          li;
    int unsigned visits;
    longint      sep;
    node_t       nd;
    plane_t      pl;
    r.leaf = '0;
    r.err = 1'b1;
    cur = 0;
    visits = 0;
    while (visits < DEPTH_LIMIT) begin
      if (cur >= NODE_CNT) return 1'b1;
      if (!node_set[cur]) return 1'b0;
      nd = node_mem[cur];
      sep = 0;
      if (nd.plane < PLANE_CNT) begin
        if (!plane_set[nd.plane]) return 1'b0;
        pl = plane_mem[nd.plane];
        sep = longint'($signed(w.px)) * longint'($signed(pl.nx))
            + longint'($signed(w.py)) * longint'($signed(pl.ny))
            + longint'($signed(w.pz)) * longint'($signed(pl.nz))
            - longint'($signed(pl.off)) * 16384;
      end
      hop = (sep >= 0) ? int'($signed(nd.front)) : int'($signed(nd.back));
      visits++;
      if (hop < 0) begin
        li = -(hop + 1);
        if (li < LEAF_CNT) begin
          r.leaf = li[LEAF_W-1:0];
          r.err = 1'b0;
        end
        return 1'b1;
      end
      cur = hop;
    end
    return 1'b1;
  endfunction

  function automatic cmd_t noise_word(input logic [1:0] kind);
    cmd_t w;
    w.op = kind;
    w.slot = SLOT_W'($urandom);
    w.nx = NORM_W'($urandom);
    w.ny = NORM_W'($urandom);
    w.nz = NORM_W'($urandom);
    w.off = COORD_W'($urandom);
    w.plane = SLOT_W'($urandom);
    w.front = CHILD_W'($urandom);
    w.back = CHILD_W'($urandom);
    w.px = COORD_W'($urandom);
    w.py = COORD_W'($urandom);
    w.pz = COORD_W'($urandom);
    return w;
  endfunction

  function automatic logic signed [CHILD_W-1:0] child_for(input int unsigned k,
                                                           input bit to_node);
    int unsigned pick;
    pick = $urandom_range(0, 47);
    if (pick == 0)
      return $signed({2'b00, tree_nodes[$urandom_range(0, tree_size - 1)]});
    if (k + 1 < tree_size && to_node)
      return $signed({2'b00, tree_nodes[k + 1]});
    if (k + 1 < tree_size && pick < 28)
      return $signed({2'b00, tree_nodes[$urandom_range(k + 1, tree_size - 1)]});
    case (pick % 4)
      0:       return CHILD_W'(-1);
      1:       return CHILD_W'(-8192);
      default: return CHILD_W'(-(1 + int'($urandom_range(0, 8191))));
    endcase
  endfunction

  task automatic flag_error(input string msg);
    n_fail++;
    if (n_fail <= 10) $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  task automatic push_word(input cmd_t w);
    located_t    r;
    int unsigned gap;
    gap = (!tx_steady && $urandom_range(0, 5) == 0) ? $urandom_range(1, 8) : 0;
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid   <= 1'b1;
    op           <= w.op;
    entry_index  <= w.slot;
    normal_x     <= w.nx;
    normal_y     <= w.ny;
    normal_z     <= w.nz;
    plane_ofs    <= w.off;
    node_plane   <= w.plane;
    front_child  <= w.front;
    back_child   <= w.back;
    point_x      <= w.px;
    point_y      <= w.py;
    point_z      <= w.pz;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    case (w.op)
      OP_PLANE: begin
        plane_mem[w.slot] = {w.nx, w.ny, w.nz, w.off};
        plane_set[w.slot] = 1'b1;
        n_plane++;
        n_words++;
      end
      OP_NODE: begin
        node_mem[w.slot] = {w.plane, w.front, w.back};
        node_set[w.slot] = 1'b1;
        n_node++;
        n_words++;
      end
      OP_LOCATE: begin
        void'(locate(w, r));
        leaf_due.push_back(r);
        n_query++;
        n_words++;
        if (r.err) n_deep++;
      end
      default: n_dropped++;
    endcase
  endtask

  task automatic stop_items();
    item_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    stop_items();
    while (leaf_due.size() != 0) @(posedge clk);
  endtask

  task automatic send_plane(input int slot, input int nx, input int ny, input int nz,
                            input int off);
    cmd_t w;
    w = noise_word(OP_PLANE);
    w.slot = SLOT_W'(slot);
    w.nx = NORM_W'(nx);
    w.ny = NORM_W'(ny);
    w.nz = NORM_W'(nz);
    w.off = COORD_W'(off);
    push_word(w);
  endtask

  task automatic send_node(input int slot, input int plane, input int front,
                           input int back);
    cmd_t w;
    w = noise_word(OP_NODE);
    w.slot = SLOT_W'(slot);
    w.plane = SLOT_W'(plane);
    w.front = CHILD_W'(front);
    w.back = CHILD_W'(back);
    push_word(w);
  endtask

  task automatic send_query(input int px, input int py, input int pz);
    cmd_t     w;
    located_t r;
    w = noise_word(OP_LOCATE);
    w.px = COORD_W'(px);
    w.py = COORD_W'(py);
    w.pz = COORD_W'(pz);
    if (locate(w, r)) push_word(w);
    else n_skipped++;
  endtask

  task automatic tree_episode(input int unsigned np, input int unsigned nn,
                              input int unsigned nq, input bit chain);
    int          corner [5] = '{8388607, -8388608, 0, -1, 1};
    cmd_t        w;
    plane_t      pl;
    int unsigned k;
    int unsigned side;
    int          px, py, pz;
    for (k = 0; k < np; k++) begin
      w = noise_word(OP_PLANE);
      if ($urandom_range(0, 2) == 0) begin
        w.nx = '0;
        w.ny = '0;
        w.nz = '0;
        case ($urandom_range(0, 2))
          0:       w.nx = NORM_W'(16384);
          1:       w.ny = NORM_W'(16384);
          default: w.nz = NORM_W'(16384);
        endcase
      end
      tree_planes[k] = w.slot;
      push_word(w);
    end
    tree_size = nn;
    tree_nodes[0] = '0;
    for (k = 1; k < nn; k++) tree_nodes[k] = SLOT_W'($urandom);
    for (k = nn; k > 0; k--) begin
      side = $urandom_range(0, 1);
      w = noise_word(OP_NODE);
      w.slot = tree_nodes[k - 1];
      w.plane = tree_planes[$urandom_range(0, np - 1)];
      w.front = child_for(k - 1, chain && side == 0);
      w.back = child_for(k - 1, chain && side == 1);
      push_word(w);
    end
    for (k = 0; k < nq; k++) begin
      case ($urandom_range(0, 9))
        0:       push_word(noise_word(OP_NONE));
        1:       push_word(noise_word(OP_PLANE));
        2:       push_word(noise_word(OP_NODE));
        default: ;
      endcase
      px = int'($urandom);
      py = int'($urandom);
      pz = int'($urandom);
      case ($urandom_range(0, 5))
        0: begin
          px = int'($urandom_range(0, 1023)) - 512;
          py = int'($urandom_range(0, 1023)) - 512;
          pz = int'($urandom_range(0, 1023)) - 512;
        end
        1: begin
          px = corner[$urandom_range(0, 4)];
          py = corner[$urandom_range(0, 4)];
          pz = corner[$urandom_range(0, 4)];
        end
        2: begin
          // land exactly on an axis-aligned plane
          pl = plane_mem[tree_planes[$urandom_range(0, np - 1)]];
          if (pl.ny == 0 && pl.nz == 0 && pl.nx == 16384) px = int'($signed(pl.off));
          if (pl.nx == 0 && pl.nz == 0 && pl.ny == 16384) py = int'($signed(pl.off));
          if (pl.nx == 0 && pl.ny == 0 && pl.nz == 16384) pz = int'($signed(pl.off));
        end
        default: ;
      endcase
      send_query(px, py, pz);
    end
    if (!tx_steady && $urandom_range(0, 7) == 0) wait_drained();
  endtask

  task automatic random_episode();
    bit chain;
    chain = ($urandom_range(0, 7) == 0);
    tree_episode($urandom_range(1, 6), chain ? $urandom_range(20, 60) : $urandom_range(1, 10),
                 $urandom_range(4, 24), chain);
  endtask

  task automatic test_directed();
    send_plane(0, 16384, 0, 0, 0);
    send_plane(1, 0, 0, 0, 0);
    send_plane(2, 16384, 16384, 16384, 8388607);
    send_plane(4095, -32768, 32767, -1, -8388608);
    send_node(4095, 4095, -8192, -1);
    send_node(2, 1, 2, 0);
    send_node(1, 2, 2, -4097);
    send_node(0, 0, 4095, 1);
    push_word(noise_word(OP_NONE));
    send_query(0, 0, 0);
    send_query(1, 0, 0);
    send_query(8388607, -8388608, 8388607);
    send_query(-1, 0, 0);
    send_query(-1, 8388607, 8388607);
    send_query(-8388608, -8388608, -8388608);
    send_query(8388607, 8388607, 8388607);
    wait_drained();
  endtask

  task automatic test_full_stall();
    int unsigned k;
    tree_episode(3, 6, 0, 1'b0);
    tx_steady = 1'b1;
    hold_req <= ~hold_req;
    for (k = 0; k < 20; k++) send_query(int'($urandom), int'($urandom), int'($urandom));
    tx_steady = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_trees();
    while (n_words < 1500) random_episode();
  endtask

  task automatic test_steady_tail();
    tx_steady = 1'b1;
    rx_steady <= 1'b1;
    while (n_words < 2000) random_episode();
  endtask

  always @(posedge clk) begin : result_pace
    int unsigned nxt;
    if (rst) begin
      stall_left = 0;
      result_ready <= 1'b0;
    end else begin
      nxt = (stall_left != 0) ? stall_left - 1 : 0;
      if (hold_req != hold_ack) begin
        hold_ack <= hold_req;
        nxt = LONG_HOLD;
      end else if (nxt == 0 && !rx_steady && $urandom_range(0, 11) == 0) begin
        nxt = $urandom_range(1, 8);
      end
      stall_left = nxt;
      result_ready <= (nxt == 0);
    end
  end

  always @(posedge clk) begin : leaf_check
    located_t want;
    if (!rst && result_valid && result_ready) begin
      n_checked++;
      if (leaf_due.size() == 0) begin
        flag_error($sformatf("result with no locate pending: leaf_index %0d depth_error %0b",
                             leaf_index, depth_error));
      end else begin
        want = leaf_due.pop_front();
        if (leaf_index !== want.leaf)
          flag_error($sformatf("result %0d: leaf_index expected %0d, got %0d",
                               n_checked, want.leaf, leaf_index));
        if (depth_error !== want.err)
          flag_error($sformatf("result %0d: depth_error expected %0b, got %0b",
                               n_checked, want.err, depth_error));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Timeout: %0d cycles without a transfer, %0d locates pending",
               quiet_cycles, leaf_due.size());
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_stall();
    test_random_trees();
    test_steady_tail();
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    $display("Loaded %0d planes and %0d nodes, sent %0d locates (%0d failing the walk), %0d ignored.",
             n_plane, n_node, n_query, n_deep, n_dropped);
    $display("Compared %0d results with %0d errors; %0d unsafe queries held back.",
             n_checked, n_fail, n_skipped);
    if (n_fail == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
